@@ hdl/http_chunked_stream_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// http_chunked_stream_decoder_top_macros.svh
// assertion macros shared by the chunked stream decoder
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_STREAM_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define HCSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hcsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_pkg
// types, character codes and digit decode for the chunked stream decoder
// ----------------------------------------------------------------------------
package hcsd_pkg;

  // framing characters
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_SEMI = 8'h3B;
  localparam logic [7:0] CHR_0    = 8'h30;
  localparam logic [7:0] CHR_9    = 8'h39;
  localparam logic [7:0] CHR_LA   = 8'h61;
  localparam logic [7:0] CHR_LF_A = 8'h66;
  localparam logic [7:0] CHR_UA   = 8'h41;
  localparam logic [7:0] CHR_UF   = 8'h46;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  // parse mode, one-hot
  typedef enum logic [5:0] {
    MODE_START = 6'b000001,
    MODE_SIZE  = 6'b000010,
    MODE_LF    = 6'b000100,
    MODE_DATA  = 6'b001000,
    MODE_EXT   = 6'b010000,
    MODE_ERR   = 6'b100000
  } mode_t;

  // result of one parse step
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       last;
    logic       err;
  } step_res_t;

  // true when the byte is a hex digit
  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= CHR_0) && (b <= CHR_9)) ||
           ((b >= CHR_LA) && (b <= CHR_LF_A)) ||
           ((b >= CHR_UA) && (b <= CHR_UF));
  endfunction

  // value of a hex digit, meaningful only when is_hex holds
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if ((b >= CHR_0) && (b <= CHR_9)) begin
      v = b - CHR_0;
    end else if ((b >= CHR_LA) && (b <= CHR_LF_A)) begin
      v = b - CHR_LA + {4'd0, HEX_TEN};
    end else begin
      v = b - CHR_UA + {4'd0, HEX_TEN};
    end
    return v[3:0];
  endfunction

endpackage

@@ hdl/hcsd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_step
// next parse mode, next count and result for one word of the body
// ----------------------------------------------------------------------------
module hcsd_step import hcsd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  mode_t                mode_i,
  input  logic [SIZE_BITS-1:0] rem_i,
  input  logic [7:0]           byte_i,
  output mode_t                mode_o,
  output logic [SIZE_BITS-1:0] rem_o,
  output step_res_t            res_o
);

  logic [SIZE_BITS-1:0] size_base;
  logic [SIZE_BITS-1:0] rem_dec;
  logic                 size_full;

  // start of line clears the size before the digit goes in
  assign size_base = (mode_i == MODE_START) ? '0 : rem_i;
  assign size_full = (size_base[SIZE_BITS-1 -: 4] != 4'd0);
  assign rem_dec   = rem_i - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // per-mode decode
  always_comb begin
    mode_o = mode_i;
    rem_o  = rem_i;
    res_o  = '0;
    unique case (mode_i)
      MODE_START, MODE_SIZE: begin
        rem_o = size_base;
        if (is_hex(byte_i)) begin
          if (size_full) begin
            mode_o     = MODE_ERR;
            res_o.emit = 1'b1;
            res_o.err  = 1'b1;
          end else begin
            mode_o = MODE_SIZE;
            rem_o  = {size_base[SIZE_BITS-5:0], hex_val(byte_i)};
          end
        end else if (byte_i == CHR_CR) begin
          mode_o = MODE_LF;
        end else if (byte_i == CHR_SEMI) begin
          mode_o = MODE_EXT;
        end else begin
          mode_o     = MODE_ERR;
          res_o.emit = 1'b1;
          res_o.err  = 1'b1;
        end
      end
      MODE_EXT: begin
        if (byte_i == CHR_CR) begin
          mode_o = MODE_LF;
        end
      end
      MODE_LF: begin
        if (byte_i != CHR_LF) begin
          mode_o     = MODE_ERR;
          res_o.emit = 1'b1;
          res_o.err  = 1'b1;
        end else begin
          mode_o = (rem_i != '0) ? MODE_DATA : MODE_START;
        end
      end
      MODE_DATA: begin
        if (rem_i == '0) begin
          mode_o = MODE_START;
        end else begin
          rem_o      = rem_dec;
          res_o.emit = 1'b1;
          res_o.data = byte_i;
          if (rem_dec == '0) begin
            mode_o     = MODE_START;
            res_o.last = 1'b1;
          end
        end
      end
      default: begin
        // error state and meaningless codes stay silent
        mode_o = mode_i;
      end
    endcase
  end

endmodule

@@ hdl/http_chunked_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// An accepted word goes to the input register and its result, if any, to the result register.
// One word per cycle unless out_stall holds; the parse step is a single pass between them.
// A word that only moves framing state gives no result.
// Reset (rst_n low, synchronous) clears mode to start of size line, the count and both valids.
// ----------------------------------------------------------------------------
// http_chunked_stream_decoder_top
// strips chunked transfer framing from a byte stream
// ----------------------------------------------------------------------------
module http_chunked_stream_decoder_top import hcsd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_last_in_chunk,
  output logic       out_framing_error
);

  `include "http_chunked_stream_decoder_top_macros.svh"

  logic                 in_vld_r;
  logic                 in_vld_nxt;
  logic [7:0]           in_byte_r;
  mode_t                mode_r;
  mode_t                mode_nxt;
  logic [SIZE_BITS-1:0] rem_r;
  logic [SIZE_BITS-1:0] rem_nxt;
  logic                 out_vld_r;
  logic                 out_vld_nxt;
  logic [7:0]           out_data_r;
  logic                 out_last_r;
  logic                 out_err_r;
  step_res_t            step_res;
  logic                 advance;
  logic                 in_take;

  // word moves on when the result slot is free or being emptied
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  hcsd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .mode_i (mode_r),
    .rem_i  (rem_r),
    .byte_i (in_byte_r),
    .mode_o (mode_nxt),
    .rem_o  (rem_nxt),
    .res_o  (step_res)
  );

  // valid flags
  always_comb begin
    in_vld_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    if (advance) begin
      out_vld_nxt = step_res.emit;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_START;
      rem_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        mode_r <= mode_nxt;
        rem_r  <= rem_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_in;
    end
    if (advance && step_res.emit) begin
      out_data_r <= step_res.data;
      out_last_r <= step_res.last;
      out_err_r  <= step_res.err;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_data_byte     = out_data_r;
  assign out_last_in_chunk = out_last_r;
  assign out_framing_error = out_err_r;

  // checks
  `HCSD_ASSERT_NOW(a_err_clean, out_vld_r && out_err_r, (out_data_r == 8'd0) && !out_last_r, "error result carries payload")
  `HCSD_ASSERT_NEXT(a_err_sticky, mode_r == MODE_ERR, mode_r == MODE_ERR, "left error state without reset")
  `HCSD_ASSERT_NOW(a_data_count, mode_r == MODE_DATA, rem_r != '0, "data mode with empty count")
  `HCSD_ASSERT_NOW(a_last_start, out_vld_r && out_last_r, mode_r == MODE_START, "chunk end without new size line")

endmodule
